[hdl/anvd_pkg.sv]
package anvd_pkg;

    // frame length default
    localparam int FRAME_LEN_DEF = 512;

    // field and state widths
    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 15;
    localparam int GAIN_W   = 16;
    localparam int FACT_W   = 12;
    localparam int CNT6_W   = 6;
    localparam int THR_O_W  = 16;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 40;

    // square root unit
    localparam int RAD_W      = VAR_W + 8;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQ_CNT_W   = $clog2(SQRT_STEPS);

    // multiply-accumulate unit
    localparam int OPND_W   = 24;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int ACC_W    = 58;
    localparam int HI_SHIFT = 24;
    localparam int RND_W    = 16;
    localparam int Q16_LSB  = 16;
    localparam int Q8_LSB   = 8;
    localparam int THR_W    = 21;

    localparam logic [RND_W-1:0]  RND_Q16  = 16'h8000;
    localparam logic [RND_W-1:0]  RND_Q8   = 16'h0080;
    localparam logic [OPND_W-1:0] Q8_ONE   = 24'd256;
    localparam logic [GAIN_W:0]   GAIN_ONE = 17'h10000;

    // register reset values
    localparam logic [GAIN_W-1:0] NOISE_GAIN_RST  = 16'd1311;
    localparam logic [FACT_W-1:0] THR_FACTOR_RST  = 12'd512;
    localparam logic [PEAK_W-1:0] MUTE_LEVEL_RST  = 15'd10;
    localparam logic [CNT6_W-1:0] SKIP_AFTER_RST  = 6'd50;
    localparam logic [CNT6_W-1:0] FLUSH_AT_RST    = 6'd25;
    localparam logic [MEAN_W-1:0] NOISE_MEAN_RST  = 24'd102400;
    localparam logic [VAR_W-1:0]  NOISE_VAR_RST   = 40'd640000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MUL,
        ST_ADD,
        ST_CALC,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_MEAN_SH,
        OP_K_S,
        OP_M_NG,
        OP_V8_G,
        OP_D_D,
        OP_VLO_NG,
        OP_VHI_NG,
        OP_D2LO_G,
        OP_D2HI_G
    } mac_op_t;

    typedef enum logic [2:0] {
        REG_NOISE_GAIN,
        REG_THR_FACTOR,
        REG_MUTE_LEVEL,
        REG_SKIP_AFTER,
        REG_FLUSH_AT
    } cfg_reg_t;

    typedef struct packed {
        logic             mul_en;
        logic             add_en;
        logic             first;
        logic             hi;
        logic [RND_W-1:0] rnd;
    } mac_ctrl_t;

endpackage

[hdl/anvd_sqrt.sv]
module anvd_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [anvd_pkg::RAD_W-1:0]     radicand,
    output logic [anvd_pkg::ROOT_W-1:0]    root,
    output logic                           done
);

    localparam int RW = anvd_pkg::ROOT_W;

    logic [anvd_pkg::RAD_W-1:0]    rad_reg, rad_next;
    logic [RW:0]                   rem_reg, rem_next;
    logic [RW-1:0]                 root_reg, root_next;
    logic [anvd_pkg::SQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          fits;
    logic          last_step;

    // one result bit per cycle: bring down two radicand bits, try 4r+1
    assign rem_sh    = {rem_reg, rad_reg[anvd_pkg::RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = rem_sh >= trial;
    assign diff      = rem_sh - trial;
    assign last_step = cnt_reg == anvd_pkg::SQ_CNT_W'(anvd_pkg::SQRT_STEPS - 1);

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = rad_reg << 2;
            rem_next  = fits ? diff[RW:0] : rem_sh[RW:0];
            root_next = {root_reg[RW-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[hdl/anvd_mac.sv]
module anvd_mac (
    input  logic                          aclk,
    input  anvd_pkg::mac_ctrl_t           ctrl,
    input  logic [anvd_pkg::OPND_W-1:0]   opnd_a,
    input  logic [anvd_pkg::OPND_W-1:0]   opnd_b,
    output logic [anvd_pkg::ACC_W-1:0]    acc_sum
);

    logic [anvd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [anvd_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [anvd_pkg::ACC_W-1:0]  prod_ext;

    assign prod_next = opnd_a * opnd_b;

    // upper partial products land 24 bits up
    assign prod_ext = ctrl.hi ? (anvd_pkg::ACC_W'(prod_reg) << anvd_pkg::HI_SHIFT)
                              : anvd_pkg::ACC_W'(prod_reg);
    assign acc_sum  = acc_reg + prod_ext;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.mul_en && ctrl.first) begin
            acc_next = anvd_pkg::ACC_W'(ctrl.rnd);
        end else if (ctrl.add_en) begin
            acc_next = acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

endmodule

[hdl/adaptive_noise_voice_detector.sv]
// Adaptive-noise voice detector. Audio words (signed 16-bit samples) come in
// on the s_ stream, s_tlast marking the last sample of a frame; a frame also
// closes by itself on its FRAME_LEN-th sample. For each frame one result word
// goes out on the m_ stream: voice / muted / skip / flush flags, the frame's
// positive peak and the rounded noise threshold used (0 for a muted frame).
// Noise is tracked as a running mean (Q16.8) and variance (Q32.8) of the
// peak, clipped to the threshold, through a first-order IIR with gain
// noise_gain; threshold = mean + threshold_factor * sqrt(variance).
// Rate: samples that do not close a frame are taken one per clock while the
// block is idle. A closing sample of an unmuted frame keeps s_tready low
// through the bit-serial square root (one root bit per cycle), then nine
// 24x24 products through one shared multiplier (multiply, then accumulate),
// a clip and difference step after the second product, and a step to post
// the result. A muted frame goes straight to posting. Posting waits while
// the previous result word is held on m_; s_tready stays low meanwhile.
// Config registers (APB, byte address 4*i): noise_gain, threshold_factor,
// mute_level, skip_after, flush_at; write them only while the block is idle.
module adaptive_noise_voice_detector #(
    parameter int FRAME_LEN = anvd_pkg::FRAME_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // frame_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] voice_found, [1] frame_muted, [2] skip_frame, [3] force_flush,
    // [18:4] frame_peak, [34:19] noise_threshold, [39:35] zero
    output logic [39:0] m_tdata,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W  = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
    localparam int PW     = anvd_pkg::PEAK_W;
    localparam int GW     = anvd_pkg::GAIN_W;
    localparam int MW     = anvd_pkg::MEAN_W;
    localparam int VW     = anvd_pkg::VAR_W;
    localparam int TW     = anvd_pkg::THR_W;
    localparam int OW     = anvd_pkg::OPND_W;
    localparam int AW     = anvd_pkg::ACC_W;
    localparam int CW6    = anvd_pkg::CNT6_W;
    localparam int TOW    = anvd_pkg::THR_O_W;
    localparam int V8_W   = PW + 8;
    localparam int Q16    = anvd_pkg::Q16_LSB;
    localparam int Q8     = anvd_pkg::Q8_LSB;

    typedef struct packed {
        logic [4:0]     pad;
        logic [TOW-1:0] thr;
        logic [PW-1:0]  peak;
        logic           flush;
        logic           skip;
        logic           muted;
        logic           voice;
    } out_word_t;

    // control
    anvd_pkg::state_t  state_reg, state_next;
    anvd_pkg::mac_op_t op_reg, op_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    // model state
    logic [PW-1:0]     peak_reg, peak_next;
    logic [MW-1:0]     mean_reg, mean_next;
    logic [VW-1:0]     var_reg, var_next;
    logic [CW6-1:0]    silent_reg, silent_next;

    // config
    logic [GW-1:0]              gain_reg, gain_next;
    logic [anvd_pkg::FACT_W-1:0] factor_reg, factor_next;
    logic [PW-1:0]              mute_reg, mute_next;
    logic [CW6-1:0]             skip_reg, skip_next;
    logic [CW6-1:0]             flush_reg, flush_next;

    // per-frame working values
    logic [PW-1:0]     fpeak_reg, fpeak_next;
    logic              muted_reg, muted_next;
    logic              voice_reg, voice_next;
    logic [TW-1:0]     thr_reg, thr_next;
    logic [V8_W-1:0]   v8_reg, v8_next;
    logic [MW-1:0]     d_reg, d_next;
    logic [VW-1:0]     d2_reg, d2_next;
    out_word_t         m_word_reg, m_word_next;

    // combinational
    logic              s_accept;
    logic              frame_close;
    logic [PW-1:0]     pk_new;
    logic              muted_new;
    logic              out_free;
    logic [GW:0]       ngain;
    logic              cfg_wr;
    logic              sqrt_start;
    logic              sqrt_done;
    logic [anvd_pkg::ROOT_W-1:0] sqrt_root;
    anvd_pkg::mac_ctrl_t mac_ctrl;
    logic [OW-1:0]     opnd_a, opnd_b;
    logic [AW-1:0]     acc_sum;
    logic              clip;
    logic [PW-1:0]     vol;
    logic [MW-1:0]     v8_ext;
    logic [MW-1:0]     mean_sat;
    logic [VW-1:0]     var_sat;
    logic [CW6-1:0]    silent_upd;
    logic              voice_eff;
    logic              skip_now;

    assign s_tready  = state_reg == anvd_pkg::ST_IDLE;
    assign s_accept  = s_tvalid && s_tready;
    assign pk_new    = (!s_tdata[15] && (s_tdata[PW-1:0] > peak_reg)) ? s_tdata[PW-1:0]
                                                                       : peak_reg;
    assign frame_close = s_tlast || (cnt_reg == CNT_W'(FRAME_LEN - 1));
    assign muted_new = pk_new < mute_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign ngain     = anvd_pkg::GAIN_ONE - {1'b0, gain_reg};

    // ---------------------------------------------------------------
    // config port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        gain_next   = gain_reg;
        factor_next = factor_reg;
        mute_next   = mute_reg;
        skip_next   = skip_reg;
        flush_next  = flush_reg;
        if (cfg_wr) begin
            unique case (anvd_pkg::cfg_reg_t'(paddr[4:2]))
                anvd_pkg::REG_NOISE_GAIN: gain_next   = pwdata[GW-1:0];
                anvd_pkg::REG_THR_FACTOR: factor_next = pwdata[anvd_pkg::FACT_W-1:0];
                anvd_pkg::REG_MUTE_LEVEL: mute_next   = pwdata[PW-1:0];
                anvd_pkg::REG_SKIP_AFTER: skip_next   = pwdata[CW6-1:0];
                anvd_pkg::REG_FLUSH_AT:   flush_next  = pwdata[CW6-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (anvd_pkg::cfg_reg_t'(paddr[4:2]))
            anvd_pkg::REG_NOISE_GAIN: prdata = 32'(gain_reg);
            anvd_pkg::REG_THR_FACTOR: prdata = 32'(factor_reg);
            anvd_pkg::REG_MUTE_LEVEL: prdata = 32'(mute_reg);
            anvd_pkg::REG_SKIP_AFTER: prdata = 32'(skip_reg);
            anvd_pkg::REG_FLUSH_AT:   prdata = 32'(flush_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            anvd_pkg::ST_IDLE: begin
                op_next = anvd_pkg::OP_MEAN_SH;
                if (s_accept && frame_close) begin
                    state_next = muted_new ? anvd_pkg::ST_DONE : anvd_pkg::ST_SQRT;
                end
            end
            anvd_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    state_next = anvd_pkg::ST_MUL;
                end
            end
            anvd_pkg::ST_MUL: state_next = anvd_pkg::ST_ADD;
            anvd_pkg::ST_ADD: begin
                state_next = anvd_pkg::ST_MUL;
                unique case (op_reg)
                    anvd_pkg::OP_MEAN_SH: op_next = anvd_pkg::OP_K_S;
                    anvd_pkg::OP_K_S: begin
                        op_next    = anvd_pkg::OP_M_NG;
                        state_next = anvd_pkg::ST_CALC;
                    end
                    anvd_pkg::OP_M_NG:   op_next = anvd_pkg::OP_V8_G;
                    anvd_pkg::OP_V8_G:   op_next = anvd_pkg::OP_D_D;
                    anvd_pkg::OP_D_D:    op_next = anvd_pkg::OP_VLO_NG;
                    anvd_pkg::OP_VLO_NG: op_next = anvd_pkg::OP_VHI_NG;
                    anvd_pkg::OP_VHI_NG: op_next = anvd_pkg::OP_D2LO_G;
                    anvd_pkg::OP_D2LO_G: op_next = anvd_pkg::OP_D2HI_G;
                    anvd_pkg::OP_D2HI_G: state_next = anvd_pkg::ST_DONE;
                    default:             state_next = anvd_pkg::ST_DONE;
                endcase
            end
            anvd_pkg::ST_CALC: state_next = anvd_pkg::ST_MUL;
            anvd_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = anvd_pkg::ST_IDLE;
                end
            end
            default: state_next = anvd_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: unit controls and operand select
    // ---------------------------------------------------------------
    always_comb begin
        sqrt_start      = (state_reg == anvd_pkg::ST_IDLE) && s_accept && frame_close
                          && !muted_new;
        mac_ctrl.mul_en = state_reg == anvd_pkg::ST_MUL;
        mac_ctrl.add_en = state_reg == anvd_pkg::ST_ADD;
        mac_ctrl.first  = (op_reg == anvd_pkg::OP_MEAN_SH) || (op_reg == anvd_pkg::OP_M_NG)
                          || (op_reg == anvd_pkg::OP_D_D) || (op_reg == anvd_pkg::OP_VLO_NG);
        mac_ctrl.hi     = (op_reg == anvd_pkg::OP_VHI_NG) || (op_reg == anvd_pkg::OP_D2HI_G);
        mac_ctrl.rnd    = (op_reg == anvd_pkg::OP_D_D) ? anvd_pkg::RND_Q8 : anvd_pkg::RND_Q16;
        unique case (op_reg)
            anvd_pkg::OP_MEAN_SH: begin
                opnd_a = mean_reg;
                opnd_b = anvd_pkg::Q8_ONE;
            end
            anvd_pkg::OP_K_S: begin
                opnd_a = OW'(sqrt_root);
                opnd_b = OW'(factor_reg);
            end
            anvd_pkg::OP_M_NG: begin
                opnd_a = mean_reg;
                opnd_b = OW'(ngain);
            end
            anvd_pkg::OP_V8_G: begin
                opnd_a = OW'(v8_reg);
                opnd_b = OW'(gain_reg);
            end
            anvd_pkg::OP_D_D: begin
                opnd_a = d_reg;
                opnd_b = d_reg;
            end
            anvd_pkg::OP_VLO_NG: begin
                opnd_a = var_reg[OW-1:0];
                opnd_b = OW'(ngain);
            end
            anvd_pkg::OP_VHI_NG: begin
                opnd_a = OW'(var_reg[VW-1:OW]);
                opnd_b = OW'(ngain);
            end
            anvd_pkg::OP_D2LO_G: begin
                opnd_a = d2_reg[OW-1:0];
                opnd_b = OW'(gain_reg);
            end
            anvd_pkg::OP_D2HI_G: begin
                opnd_a = OW'(d2_reg[VW-1:OW]);
                opnd_b = OW'(gain_reg);
            end
            default: begin
                opnd_a = '0;
                opnd_b = '0;
            end
        endcase
    end

    anvd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({var_reg, 8'h00}),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    anvd_mac u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b),
        .acc_sum (acc_sum)
    );

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    // clip: peak above threshold is voice; filter sees the threshold instead
    assign clip   = {{(TW-PW){1'b0}}, fpeak_reg} > thr_reg;
    assign vol    = clip ? thr_reg[PW-1:0] : fpeak_reg;
    assign v8_ext = MW'({vol, 8'h00});

    // IIR results are Q.16 scaled; saturate to the state widths
    assign mean_sat = (|acc_sum[AW-1:Q16+MW]) ? {MW{1'b1}} : acc_sum[Q16+MW-1:Q16];
    assign var_sat  = (|acc_sum[AW-1:Q16+VW]) ? {VW{1'b1}} : acc_sum[Q16+VW-1:Q16];

    // silent-frame counter and skip / flush decision
    assign voice_eff  = voice_reg && !muted_reg;
    assign silent_upd = voice_eff ? '0
                      : ((silent_reg >= skip_reg) ? skip_reg : silent_reg + 1'b1);
    assign skip_now   = silent_upd >= skip_reg;

    always_comb begin
        cnt_next     = cnt_reg;
        peak_next    = peak_reg;
        fpeak_next   = fpeak_reg;
        muted_next   = muted_reg;
        voice_next   = voice_reg;
        thr_next     = thr_reg;
        v8_next      = v8_reg;
        d_next       = d_reg;
        d2_next      = d2_reg;
        mean_next    = mean_reg;
        var_next     = var_reg;
        silent_next  = silent_reg;
        m_word_next  = m_word_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;

        if (s_accept) begin
            if (frame_close) begin
                cnt_next   = '0;
                peak_next  = '0;
                fpeak_next = pk_new;
                muted_next = muted_new;
            end else begin
                cnt_next  = cnt_reg + 1'b1;
                peak_next = pk_new;
            end
        end

        if (state_reg == anvd_pkg::ST_ADD) begin
            unique case (op_reg)
                anvd_pkg::OP_K_S:    thr_next  = acc_sum[Q16+TW-1:Q16];
                anvd_pkg::OP_V8_G:   mean_next = mean_sat;
                anvd_pkg::OP_D_D:    d2_next   = acc_sum[Q8+VW-1:Q8];
                anvd_pkg::OP_D2HI_G: var_next  = var_sat;
                default: ;
            endcase
        end

        if (state_reg == anvd_pkg::ST_CALC) begin
            voice_next = clip;
            v8_next    = {vol, 8'h00};
            d_next     = (v8_ext >= mean_reg) ? (v8_ext - mean_reg) : (mean_reg - v8_ext);
        end

        if ((state_reg == anvd_pkg::ST_DONE) && out_free) begin
            silent_next        = silent_upd;
            m_valid_next       = 1'b1;
            m_word_next.pad    = '0;
            m_word_next.voice  = voice_eff;
            m_word_next.muted  = muted_reg;
            m_word_next.skip   = skip_now;
            m_word_next.flush  = !skip_now && (silent_upd == flush_reg);
            m_word_next.peak   = fpeak_reg;
            if (muted_reg) begin
                m_word_next.thr = '0;
            end else if (|thr_reg[TW-1:TOW]) begin
                m_word_next.thr = {TOW{1'b1}};
            end else begin
                m_word_next.thr = thr_reg[TOW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= anvd_pkg::ST_IDLE;
            op_reg      <= anvd_pkg::OP_MEAN_SH;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            peak_reg    <= '0;
            mean_reg    <= anvd_pkg::NOISE_MEAN_RST;
            var_reg     <= anvd_pkg::NOISE_VAR_RST;
            silent_reg  <= '0;
            gain_reg    <= anvd_pkg::NOISE_GAIN_RST;
            factor_reg  <= anvd_pkg::THR_FACTOR_RST;
            mute_reg    <= anvd_pkg::MUTE_LEVEL_RST;
            skip_reg    <= anvd_pkg::SKIP_AFTER_RST;
            flush_reg   <= anvd_pkg::FLUSH_AT_RST;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            peak_reg    <= peak_next;
            mean_reg    <= mean_next;
            var_reg     <= var_next;
            silent_reg  <= silent_next;
            gain_reg    <= gain_next;
            factor_reg  <= factor_next;
            mute_reg    <= mute_next;
            skip_reg    <= skip_next;
            flush_reg   <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        fpeak_reg  <= fpeak_next;
        muted_reg  <= muted_next;
        voice_reg  <= voice_next;
        thr_reg    <= thr_next;
        v8_reg     <= v8_next;
        d_reg      <= d_next;
        d2_reg     <= d2_next;
        m_word_reg <= m_word_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_word_reg;

`ifndef SYNTH
    a_post_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == anvd_pkg::ST_DONE))
        else $error("result word posted outside the done state");

    a_skip_flush_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_word_reg.skip && m_word_reg.flush))
        else $error("skip and flush raised together");

    a_voice_not_muted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_word_reg.voice && m_word_reg.muted))
        else $error("voice reported on a muted frame");

    a_muted_thr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_word_reg.muted) |-> (m_word_reg.thr == '0))
        else $error("muted frame carries a threshold");

    a_sqrt_then_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == anvd_pkg::ST_SQRT) |=>
            (state_reg == anvd_pkg::ST_SQRT || state_reg == anvd_pkg::ST_MUL))
        else $error("square root phase left to a wrong state");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import anvd_pkg::*;

    // one result word as the predictor sees it
    typedef struct packed {
        logic        voice;
        logic        muted;
        logic        skip;
        logic        flush;
        logic [14:0] peak;
        logic [15:0] thr;
    } verdict_t;

    // Frame verdict predictor: own copy of registers and noise state, queue
    // of verdicts still owed by the block.
    class verdict_model;
        bit [15:0]  gain;
        bit [11:0]  factor;
        bit [14:0]  mute_level;
        bit [5:0]   skip_after;
        bit [5:0]   flush_at;
        bit [14:0]  peak_hold;
        bit [12:0]  sample_cnt;
        bit [23:0]  noise_mean;
        bit [39:0]  noise_var;
        bit [5:0]   silent_frames;
        verdict_t   owed[$];
        int         mismatches;

        function new();
            gain          = NOISE_GAIN_RST;
            factor        = THR_FACTOR_RST;
            mute_level    = MUTE_LEVEL_RST;
            skip_after    = SKIP_AFTER_RST;
            flush_at      = FLUSH_AT_RST;
            peak_hold     = '0;
            sample_cnt    = '0;
            noise_mean    = NOISE_MEAN_RST;
            noise_var     = NOISE_VAR_RST;
            silent_frames = '0;
            mismatches    = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void set_reg(cfg_reg_t idx, bit [31:0] val);
            case (idx)
                REG_NOISE_GAIN: gain       = val[15:0];
                REG_THR_FACTOR: factor     = val[11:0];
                REG_MUTE_LEVEL: mute_level = val[14:0];
                REG_SKIP_AFTER: skip_after = val[5:0];
                REG_FLUSH_AT:   flush_at   = val[5:0];
                default: ;
            endcase
        endfunction

        // bit-serial integer square root, floor
        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned root, probe;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > x) probe >>= 2;
            while (probe != 0) begin
                if (x >= root + probe) begin
                    x    = x - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe >>= 2;
            end
            return root;
        endfunction

        function void take_sample(bit [15:0] pcm, bit last);
            verdict_t        r;
            longint unsigned sd, t16, thr, g, ng, vol, v8, d, d2, m, v;
            bit              voice, muted, skip;
            bit [14:0]       peak;
            if (!pcm[15] && pcm[14:0] > peak_hold) peak_hold = pcm[14:0];
            sample_cnt = sample_cnt + 13'd1;
            if (!last && sample_cnt < FRAME_LEN_DEF) return;

            peak       = peak_hold;
            peak_hold  = '0;
            sample_cnt = '0;
            muted      = peak < mute_level;
            voice      = 1'b0;
            thr        = 0;
            if (!muted) begin
                // threshold = mean + k * std-dev, rounded from Q.16
                sd  = int_sqrt(64'(noise_var) << 8);
                t16 = (64'(noise_mean) << 8) + 64'(factor) * sd;
                thr = (t16 + 64'd32768) >> 16;
                vol = 64'(peak);
                if (vol > thr) begin
                    voice = 1'b1;
                    vol   = thr;
                end
                // IIR update with the clipped peak
                v8 = vol << 8;
                d  = (v8 >= 64'(noise_mean)) ? v8 - 64'(noise_mean) : 64'(noise_mean) - v8;
                d2 = (d * d + 64'd128) >> 8;
                g  = 64'(gain);
                ng = 64'd65536 - g;
                m  = (64'(noise_mean) * ng + v8 * g + 64'd32768) >> 16;
                v  = (64'(noise_var) * ng + d2 * g + 64'd32768) >> 16;
                noise_mean = (m > 64'hFF_FFFF) ? 24'hFF_FFFF : m[23:0];
                noise_var  = (v > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : v[39:0];
                if (thr > 64'd65535) thr = 64'd65535;
            end

            if (voice)
                silent_frames = '0;
            else if (silent_frames >= skip_after)
                silent_frames = skip_after;
            else
                silent_frames = silent_frames + 6'd1;
            skip = silent_frames >= skip_after;

            r.voice = voice;
            r.muted = muted;
            r.skip  = skip;
            r.flush = !skip && silent_frames == flush_at;
            r.peak  = peak;
            r.thr   = thr[15:0];
            owed.push_back(r);
        endfunction

        task log_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_verdict(bit [39:0] word);
            verdict_t e;
            if (owed.size() == 0) begin
                log_mismatch($sformatf("result word %h with no frame pending", word));
                return;
            end
            e = owed.pop_front();
            if (word[0] !== e.voice)
                log_mismatch($sformatf("voice_found %b, want %b", word[0], e.voice));
            if (word[1] !== e.muted)
                log_mismatch($sformatf("frame_muted %b, want %b", word[1], e.muted));
            if (word[2] !== e.skip)
                log_mismatch($sformatf("skip_frame %b, want %b", word[2], e.skip));
            if (word[3] !== e.flush)
                log_mismatch($sformatf("force_flush %b, want %b", word[3], e.flush));
            if (word[18:4] !== e.peak)
                log_mismatch($sformatf("frame_peak %0d, want %0d", word[18:4], e.peak));
            if (word[34:19] !== e.thr)
                log_mismatch($sformatf("noise_threshold %0d, want %0d", word[34:19], e.thr));
        endtask
    endclass

    // DUT hookup
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] sample
    logic        s_tlast;   // frame_end
    logic        m_tvalid;
    logic        m_tready;
    // [0] voice_found, [1] frame_muted, [2] skip_frame, [3] force_flush,
    // [18:4] frame_peak, [34:19] noise_threshold, [39:35] zero
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    adaptive_noise_voice_detector u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // drain margin after the last verdict: frame-end work plus a held result word
    localparam int SETTLE_CYCLES = 60;

    verdict_model verdicts;
    int           tx_max = 15;    // sender gap ceiling, toggles 0/15 for burst stretches
    int           rx_max = 15;    // receiver stall ceiling, same idea
    int           items_sent = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("adaptive_noise_voice_detector regression: fail");
        $finish;
    end

    // Both monitors sample at the edge, before any NBA lands: race free.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            verdicts.take_sample(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready)
            verdicts.check_verdict(m_tdata);
    end

    // Result side: random stall before each word, with calm stretches.
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = $urandom_range(0, rx_max);
            if ($urandom_range(0, 19) == 0) rx_max = (rx_max == 0) ? 15 : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // One sample word. tvalid is left high after the handshake so a
    // zero gap streams back to back without a drop.
    task automatic send_sample(input bit [15:0] pcm, input bit last);
        int gap;
        gap = $urandom_range(0, tx_max);
        if ($urandom_range(0, 24) == 0) tx_max = (tx_max == 0) ? 15 : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pcm;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sample level styles: quiet, around threshold, full range, negative, near top
    function automatic bit [15:0] pick_pcm(int kind);
        int v;
        if (kind <= 2)
            v = int'($urandom_range(0, 40)) - 20;
        else if (kind <= 6)
            v = int'($urandom_range(0, 1600)) - 100;
        else if (kind == 7)
            v = int'($urandom_range(0, 65535));
        else if (kind == 8)
            v = -int'($urandom_range(1, 32768));
        else
            v = int'($urandom_range(30000, 32767));
        return v[15:0];
    endfunction

    task automatic run_frames(input int n, input int max_len);
        int len, kind;
        for (int f = 0; f < n; f++) begin
            len  = $urandom_range(1, max_len);
            kind = $urandom_range(0, 9);
            for (int i = 0; i < len; i++)
                send_sample(pick_pcm(kind), i == len - 1);
            items_sent += len;
        end
    endtask

    // tlast only on the last of FRAME_LEN + extra samples: with extra > 0 the block
    // must close the frame on its own, and the tail becomes the next frame
    task automatic send_long_frame(input int extra);
        int total;
        total = FRAME_LEN_DEF + extra;
        for (int i = 0; i < total; i++)
            send_sample(pick_pcm($urandom_range(0, 9)), i == total - 1);
    endtask

    // wait for every owed verdict, then let the block drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup then access; leaves the bus in access so writes can chain
    task automatic write_reg(input cfg_reg_t idx, input bit [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        verdicts.set_reg(idx, val);
    endtask

    task automatic program_regs(input bit [15:0] gain, input bit [11:0] factor,
                                input bit [14:0] mute, input bit [5:0] skip,
                                input bit [5:0] flush);
        write_reg(REG_NOISE_GAIN, 32'(gain));
        write_reg(REG_THR_FACTOR, 32'(factor));
        write_reg(REG_MUTE_LEVEL, 32'(mute));
        write_reg(REG_SKIP_AFTER, 32'(skip));
        write_reg(REG_FLUSH_AT, 32'(flush));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        bit [15:0] r_gain;
        bit [11:0] r_factor;
        bit [14:0] r_mute;
        int        long_frames;

        verdicts = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, reset register values ---
        send_sample(16'h7FFF, 1'b1);                    // top positive peak, voice
        send_sample(16'h8000, 1'b0);                    // negatives only: peak 0, muted
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd0, 1'b0);                       // one below mute level
        send_sample(16'd9, 1'b1);
        send_sample(16'd10, 1'b1);                      // exactly mute level: live
        send_sample(16'h5555, 1'b0);                    // alternating bit patterns
        send_sample(16'hAAAA, 1'b1);
        send_sample(16'h2AAA, 1'b1);
        send_sample(16'd300, 1'b0);
        send_sample(16'hFFFB, 1'b0);
        send_sample(16'd450, 1'b1);
        items_sent += 12;

        // extremes: full gain, factor 0, never muted, skip and flush both 1
        // so skip must win over flush
        settle();
        program_regs(16'hFFFF, 12'd0, 15'd0, 6'd1, 6'd1);
        run_frames(20, 6);

        // minimum gain, max factor, nearly all muted: counter climbs to 63
        settle();
        program_regs(16'd1, 12'd4095, 15'd32767, 6'd63, 6'd40);
        run_frames(70, 2);

        // frozen model, zero skip: counter sits above skip_after, must drop
        settle();
        program_regs(16'd0, 12'd4095, 15'd5, 6'd0, 6'd63);
        run_frames(15, 5);

        // flush below skip, plus a frame of exactly FRAME_LEN samples
        settle();
        program_regs(16'd3000, 12'd300, 15'd50, 6'd10, 6'd4);
        run_frames(30, 6);
        send_long_frame(0);

        // --- random register settings ---
        long_frames = 0;
        while (items_sent < 450) begin
            settle();
            r_gain   = $urandom_range(0, 1) ? 16'($urandom_range(0, 4000))
                                            : 16'($urandom_range(0, 65535));
            r_factor = 12'($urandom_range(0, 4095));
            r_mute   = $urandom_range(0, 1) ? 15'($urandom_range(0, 200))
                                            : 15'($urandom_range(0, 32767));
            program_regs(r_gain, r_factor, r_mute, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
            run_frames(25, 10);
            if (long_frames == 0) begin
                send_long_frame($urandom_range(1, 20));
                long_frames++;
            end
        end

        settle();
        if (verdicts.mismatches == 0) begin
            $display("adaptive_noise_voice_detector regression: pass");
        end else begin
            $display("adaptive_noise_voice_detector regression: fail");
        end
        $finish;
    end

endmodule
